>>> hdl/hblp_pkg.sv
// Shared types and sizes for the hex byte line parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package hblp_pkg;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] MAX_BYTES_RESET = 8'd64;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic REG_MAX_BYTES = 1'b0;

   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       line_end;
   } hblp_item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      logic [7:0] byte_count;
      logic       line_error;
      logic       last;
   } hblp_result_type;

endpackage

`default_nettype wire

>>> hdl/hblp_core.sv
// Per-character token and line state, plus the up to two results an item makes.
// Depends on hblp_pkg.
`default_nettype none

module hblp_core
   import hblp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            fire,
   input  wire hblp_item_type   item,
   input  wire logic [7:0]      max_bytes,
   output hblp_result_type      results [2],
   output logic [1:0]           result_count
);

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LX    = 8'h78;
   localparam logic [7:0] CHAR_UX    = 8'h58;
   localparam logic [3:0] NIB_TEN    = 4'd10;

   // {valid, nibble}
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [7:0] d;
      logic [4:0] r;
      d = 8'd0;
      r = 5'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
         r = {1'b1, d[3:0]};
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         d = c - CHAR_LA;
         r = {1'b1, NIB_TEN + d[3:0]};
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d = c - CHAR_UA;
         r = {1'b1, NIB_TEN + d[3:0]};
      end
      return r;
   endfunction

   logic       in_token_ff, in_token_in;
   logic [1:0] token_chars_ff, token_chars_in;
   logic       first_was_zero_ff, first_was_zero_in;
   logic [1:0] digit_count_ff, digit_count_in;
   logic [7:0] accum_value_ff, accum_value_in;
   logic       token_bad_ff, token_bad_in;
   logic       line_failed_ff, line_failed_in;
   logic [7:0] bytes_done_ff, bytes_done_in;

   always_comb begin
      logic       is_sep;
      logic       finish;
      logic       data_ok;
      logic [1:0] pos;
      logic [4:0] nib;
      logic       status_err;
      logic [7:0] status_count;

      in_token_in       = in_token_ff;
      token_chars_in    = token_chars_ff;
      first_was_zero_in = first_was_zero_ff;
      digit_count_in    = digit_count_ff;
      accum_value_in    = accum_value_ff;
      token_bad_in      = token_bad_ff;
      line_failed_in    = line_failed_ff;
      bytes_done_in     = bytes_done_ff;

      is_sep  = (item.ch == CHAR_SPACE) || (item.ch == CHAR_TAB);
      finish  = 1'b0;
      data_ok = 1'b0;
      nib     = nibble_of(item.ch);
      pos     = 2'd0;

      if (item.has_char && !line_failed_ff) begin
         if (is_sep) begin
            finish = in_token_ff;
         end else begin
            if (!in_token_ff) begin
               in_token_in       = 1'b1;
               token_chars_in    = 2'd0;
               first_was_zero_in = 1'b0;
               digit_count_in    = 2'd0;
               accum_value_in    = 8'd0;
               token_bad_in      = 1'b0;
            end
            pos = token_chars_in;
            if (token_chars_in != 2'd2) begin
               token_chars_in = token_chars_in + 2'd1;
            end
            if (!token_bad_in) begin
               if (pos == 2'd0) begin
                  first_was_zero_in = (item.ch == CHAR_ZERO);
               end
               if (pos == 2'd1 && first_was_zero_in &&
                   (item.ch == CHAR_LX || item.ch == CHAR_UX)) begin
                  // prefix: restart the digit collection
                  digit_count_in = 2'd0;
                  accum_value_in = 8'd0;
               end else if (!nib[4] || digit_count_in == 2'd2) begin
                  token_bad_in = 1'b1;
               end else begin
                  accum_value_in = {accum_value_in[3:0], nib[3:0]};
                  digit_count_in = digit_count_in + 2'd1;
               end
            end
         end
      end

      if (item.line_end && !line_failed_ff && in_token_in) begin
         finish = 1'b1;
      end

      if (finish) begin
         in_token_in = 1'b0;
         if (token_bad_in || digit_count_in == 2'd0 || bytes_done_ff >= max_bytes) begin
            line_failed_in = 1'b1;
         end else begin
            data_ok       = 1'b1;
            bytes_done_in = bytes_done_ff + 8'd1;
         end
      end

      status_err   = line_failed_in;
      status_count = bytes_done_in;

      results[0].kind       = KIND_DATA;
      results[0].byte_value = accum_value_in;
      results[0].byte_count = bytes_done_in;
      results[0].line_error = 1'b0;
      results[0].last       = !item.line_end;
      results[1].kind       = KIND_STATUS;
      results[1].byte_value = 8'd0;
      results[1].byte_count = status_count;
      results[1].line_error = status_err;
      results[1].last       = 1'b1;
      result_count          = {1'b0, data_ok} + {1'b0, item.line_end};

      if (!data_ok) begin
         results[0] = results[1];
      end

      if (item.line_end) begin
         in_token_in       = 1'b0;
         token_chars_in    = 2'd0;
         first_was_zero_in = 1'b0;
         digit_count_in    = 2'd0;
         accum_value_in    = 8'd0;
         token_bad_in      = 1'b0;
         line_failed_in    = 1'b0;
         bytes_done_in     = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff       <= 1'b0;
         token_chars_ff    <= 2'd0;
         first_was_zero_ff <= 1'b0;
         digit_count_ff    <= 2'd0;
         accum_value_ff    <= 8'd0;
         token_bad_ff      <= 1'b0;
         line_failed_ff    <= 1'b0;
         bytes_done_ff     <= 8'd0;
      end else if (fire) begin
         in_token_ff       <= in_token_in;
         token_chars_ff    <= token_chars_in;
         first_was_zero_ff <= first_was_zero_in;
         digit_count_ff    <= digit_count_in;
         accum_value_ff    <= accum_value_in;
         token_bad_ff      <= token_bad_in;
         line_failed_ff    <= line_failed_in;
         bytes_done_ff     <= bytes_done_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/hblp_rsp_queue.sv
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on hblp_pkg.
`default_nettype none

module hblp_rsp_queue
   import hblp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire hblp_result_type push_data [2],
   input  wire logic [1:0]      push_count,
   output logic                 space_ok,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output hblp_result_type      out_data
);

   hblp_result_type        entries_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // room for the worst case of two results
   assign space_ok  = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push_count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push_data[1];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overfilled");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> space_ok)
      else $error("results pushed without room");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == RSP_CNT_W'($past(count_ff)
         + RSP_CNT_W'($past(push_count)) - RSP_CNT_W'($past(pop))))
      else $error("result queue count out of step with pushes and pops");

endmodule

`default_nettype wire

>>> hdl/hex_byte_line_parser.sv
// Top level of the hex byte line parser: input register, config register, core, queue.
// Depends on hblp_pkg, hblp_core and hblp_rsp_queue.
`default_nettype none

// Accepts one character item per cycle while the result queue has room and
// turns a line of space or tab separated hex tokens (one or two digits,
// optional 0x/0X prefix) into data byte results, followed by one status
// result at line end with the byte count and an error flag. An item is held
// in the input register on accept, parsed by the core once the queue can take
// both possible results, and its results are written to the result queue that
// feeds the rsp_ port. An item that yields both a byte and a status puts two
// results on the single result port; the four-entry result queue absorbs that
// burst. The only register is max_bytes at address 0 (reset 64); change it
// only while no line item is in flight.
module hex_byte_line_parser
   import hblp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_has_char,
   input  wire logic        req_line_end,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [7:0]       rsp_byte_value,
   output logic [7:0]       rsp_byte_count,
   output logic             rsp_line_error,
   output logic             rsp_last,
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic            in_valid_ff;
   hblp_item_type   in_item_ff;
   logic [7:0]      max_bytes_ff;
   logic            space_ok;
   logic            fire;
   hblp_result_type core_results [2];
   logic [1:0]      core_count;
   logic [1:0]      push_count;
   hblp_result_type rsp_data;

   // Parse the held item as soon as the queue can take both possible results.
   assign fire      = in_valid_ff && space_ok;
   assign req_ready = !in_valid_ff || space_ok;
   assign push_count = fire ? core_count : 2'd0;

   // Hold the accepted item; drop it once parsed unless a new one replaces it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.ch       <= req_ch;
         in_item_ff.has_char <= req_has_char;
         in_item_ff.line_end <= req_line_end;
      end
   end

   // Configuration: pready is held high, one register.
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_MAX_BYTES) begin
         max_bytes_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_MAX_BYTES) ? {24'd0, max_bytes_ff} : 32'd0;

   hblp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (in_item_ff),
      .max_bytes    (max_bytes_ff),
      .results      (core_results),
      .result_count (core_count)
   );

   hblp_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (core_results),
      .push_count (push_count),
      .space_ok   (space_ok),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   assign rsp_kind       = rsp_data.kind;
   assign rsp_byte_value = rsp_data.byte_value;
   assign rsp_byte_count = rsp_data.byte_count;
   assign rsp_line_error = rsp_data.line_error;
   assign rsp_last       = rsp_data.last;

   // A held item that cannot be parsed blocks new input.
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !space_ok) |-> !req_ready)
      else $error("input taken while held item is stalled");

   // An item with line_end always produces at least the status result.
   a_line_end_status: assert property (@(posedge clock) disable iff (reset)
      (fire && in_item_ff.line_end) |-> (push_count != 2'd0))
      else $error("line end without status result");

   // An accepted item is held valid in the next cycle.
   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> in_valid_ff)
      else $error("accepted item lost");

endmodule

`default_nettype wire
